// ===== hdl/ffdl_pkg.sv =====
// ----------------------------------------------------------------------------
// ffdl_pkg
// Shared widths, constants, register indexes, sequencer states and helpers
// of the fractional feedback delay line.
// ----------------------------------------------------------------------------
package ffdl_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 22;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DELAY_DEPTH_DEF = 16384;

    localparam int FB_LIMIT    = 16220;
    localparam int FLUSH_LIMIT = 137438;
    localparam int COEF_ONE    = 16384;
    localparam int FB_HALF     = 8192;

    // lowpass divider: quotient bits, dividend/divisor register width
    localparam int DIV_QW  = 25;
    localparam int DIV_W   = 41;
    localparam int DIV_CW  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MUTE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ON  = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADDR,
        ST_PTR,
        ST_RD1,
        ST_RD0,
        ST_CAP,
        ST_INTERP,
        ST_TAP,
        ST_FMUL,
        ST_FSUM,
        ST_FPREP,
        ST_FDIV,
        ST_FSAT,
        ST_GMUL,
        ST_FBABS,
        ST_FBRND,
        ST_WRITE,
        ST_DONE
    } ffdl_state_t;

    // saturate a signed 27-bit value to signed 24 bits
    function automatic logic signed [SAMPLE_W-1:0] sat_s24(input logic signed [26:0] v);
        logic signed [26:0] hi;
        logic signed [26:0] lo;
        hi = 27'sd8388607;
        lo = -27'sd8388608;
        if (v > hi)
        begin
            return 24'sh7FFFFF;
        end
        else if (v < lo)
        begin
            return 24'sh800000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== hdl/fractional_feedback_delay_line.sv =====
// Sequence: address, pointer, two reads, interpolation, tap; unless in hold mode, the
// optional lowpass (25-step restoring divider) and feedback gain; write-back; result
// (held back while a stalled result beat waits). Muted: zero result, no write-back.
// One item at a time; the next beat is taken the cycle after the result is registered.
// Reset: asynchronous, active low; clears pointer, fill flag, filter memory; config to
// defaults. The store is not swept: entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line
// Circular delay store with fractional tap (interpolation optional), optional one-pole
// lowpass and saturated feedback write-back.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line #(
    parameter int DELAY_DEPTH = ffdl_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [ffdl_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic [ffdl_pkg::DELAY_W-1:0]            delay_samples,
    input  logic signed [ffdl_pkg::GAIN_W-1:0]      feedback_gain,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [ffdl_pkg::SAMPLE_W-1:0]    out_sample
);
    import ffdl_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = (AW + 8 > DELAY_W) ? AW + 8 : DELAY_W;
    localparam logic [CW-1:0] D_MIN   = CW'(256);
    localparam logic [CW-1:0] D_MAX   = CW'(DELAY_DEPTH - 1) << 8;
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

    logic signed [SAMPLE_W-1:0] delay_store [DELAY_DEPTH];

    ffdl_state_t state_reg, state_next;

    logic [AW-1:0]              wp_reg, wp_next;
    logic                       filled_reg, filled_next;
    logic signed [SAMPLE_W-1:0] fm_reg, fm_next;

    logic              mute_reg, mute_next;
    logic              hold_reg, hold_next;
    logic              interp_reg, interp_next;
    logic              filt_reg, filt_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    logic              prot_reg, prot_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;

    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [DELAY_W-1:0]         dly_reg, dly_next;
    logic signed [GAIN_W-1:0]   gain_reg, gain_next;
    logic [AW-1:0]              ip_reg, ip_next;
    logic [7:0]                 fr_reg, fr_next;
    logic [AW-1:0]              p1_reg, p1_next;
    logic [AW-1:0]              p0_reg, p0_next;
    logic signed [SAMPLE_W-1:0] x1_reg, x1_next;
    logic signed [SAMPLE_W-1:0] x0_reg, x0_next;
    logic signed [33:0]         iprod_reg, iprod_next;
    logic signed [SAMPLE_W-1:0] tap_reg, tap_next;
    logic signed [40:0]         fprod_reg, fprod_next;
    logic signed [41:0]         num_reg, num_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W-1:0]           dv_reg, dv_next;
    logic [DIV_QW-1:0]          quo_reg, quo_next;
    logic                       qneg_reg, qneg_next;
    logic [DIV_CW-1:0]          cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [39:0]         gprod_reg, gprod_next;
    logic [39:0]                pmag_reg, pmag_next;
    logic                       pneg_reg, pneg_next;
    logic                       flush_reg, flush_next;
    logic signed [25:0]         feed_reg, feed_next;

    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]              rd_addr;
    logic                       mem_we;
    logic signed [SAMPLE_W-1:0] wr_data;

    logic [CW-1:0]              d_ext;
    logic [CW-1:0]              d_clamp;
    logic [AW:0]                p1_sum;
    logic [AW:0]                p1_wrap;
    logic [AW-1:0]              p0_calc;
    logic                       v1;
    logic                       v0;
    logic signed [24:0]         diff;
    logic signed [33:0]         tap_sum;
    logic signed [SAMPLE_W-1:0] tap_val;
    logic [16:0]                den;
    logic signed [41:0]         nmag;
    logic signed [GAIN_W-1:0]   gain_c;
    logic [39:0]                prnd;
    logic [25:0]                rnd;
    logic signed [25:0]         yq;
    logic                       div_ge;

    assign d_ext   = CW'(dly_reg);
    assign d_clamp = (d_ext < D_MIN) ? D_MIN : ((d_ext > D_MAX) ? D_MAX : d_ext);

    assign p1_sum  = {1'b0, wp_reg} + (DEPTH_X - {1'b0, ip_reg});
    assign p1_wrap = (p1_sum >= DEPTH_X) ? (p1_sum - DEPTH_X) : p1_sum;
    assign p0_calc = (p1_reg == '0) ? LAST : (p1_reg - 1'b1);

    assign v1 = filled_reg || (p1_reg < wp_reg);
    assign v0 = filled_reg || (p0_reg < wp_reg);

    assign diff    = 25'(x0_reg) - 25'(x1_reg);
    assign tap_sum = 34'(x1_reg) + (iprod_reg >>> 8);
    assign tap_val = interp_reg ? tap_sum[SAMPLE_W-1:0] : x1_reg;

    assign den    = 17'(COEF_ONE) + 17'(coef_reg);
    assign nmag   = num_reg[41] ? -num_reg : num_reg;
    assign div_ge = (rem_reg >= dv_reg);
    assign yq     = qneg_reg ? -$signed(26'(quo_reg)) : $signed(26'(quo_reg));

    always_comb
    begin
        gain_c = gain_reg;
        if (prot_reg && (gain_reg > 16'(FB_LIMIT)))
        begin
            gain_c = 16'(FB_LIMIT);
        end
        else if (prot_reg && (gain_reg < -16'(FB_LIMIT)))
        begin
            gain_c = -16'(FB_LIMIT);
        end
    end

    assign prnd = pmag_reg + 40'(FB_HALF);
    assign rnd  = prnd[39:14];

    assign rd_addr = (state_reg == ST_RD0) ? p0_reg : p1_reg;
    assign mem_we  = (state_reg == ST_WRITE);
    assign wr_data = hold_reg ? tap_reg : sat_s24(27'(smp_reg) + 27'(feed_reg));

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        filled_next     = filled_reg;
        fm_next         = fm_reg;
        mute_next       = mute_reg;
        hold_next       = hold_reg;
        interp_next     = interp_reg;
        filt_next       = filt_reg;
        coef_next       = coef_reg;
        prot_next       = prot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_sample_next = out_sample_reg;
        smp_next        = smp_reg;
        dly_next        = dly_reg;
        gain_next       = gain_reg;
        ip_next         = ip_reg;
        fr_next         = fr_reg;
        p1_next         = p1_reg;
        p0_next         = p0_reg;
        x1_next         = x1_reg;
        x0_next         = x0_reg;
        iprod_next      = iprod_reg;
        tap_next        = tap_reg;
        fprod_next      = fprod_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        dv_next         = dv_reg;
        quo_next        = quo_reg;
        qneg_next       = qneg_reg;
        cnt_next        = cnt_reg;
        y_next          = y_reg;
        gprod_next      = gprod_reg;
        pmag_next       = pmag_reg;
        pneg_next       = pneg_reg;
        flush_next      = flush_reg;
        feed_next       = feed_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MUTE:        mute_next   = cfg_data[0];
                CFG_HOLD_MODE:   hold_next   = cfg_data[0];
                CFG_INTERPOLATE: interp_next = cfg_data[0];
                CFG_FILTER_ON:   filt_next   = cfg_data[0];
                CFG_FILTER_COEF: coef_next   = cfg_data[COEF_W-1:0];
                CFG_PROTECT_ON:  prot_next   = cfg_data[0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next  = in_sample;
                    dly_next  = delay_samples;
                    gain_next = feedback_gain;
                    if (mute_reg)
                    begin
                        y_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_ADDR:
            begin
                ip_next    = d_clamp[AW+7:8];
                fr_next    = d_clamp[7:0];
                state_next = ST_PTR;
            end
            ST_PTR:
            begin
                p1_next    = p1_wrap[AW-1:0];
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                p0_next    = p0_calc;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                x1_next    = v1 ? rd_data_reg : '0;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                x0_next    = v0 ? rd_data_reg : '0;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                iprod_next = $signed({1'b0, fr_reg}) * diff;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                tap_next = tap_val;
                y_next   = tap_val;
                if (hold_reg)
                begin
                    state_next = ST_WRITE;
                end
                else if (filt_reg)
                begin
                    state_next = ST_FMUL;
                end
                else
                begin
                    state_next = ST_GMUL;
                end
            end
            ST_FMUL:
            begin
                fprod_next = $signed({1'b0, coef_reg}) * fm_reg;
                state_next = ST_FSUM;
            end
            ST_FSUM:
            begin
                num_next   = (42'(tap_reg) <<< 14) + 42'(fprod_reg);
                state_next = ST_FPREP;
            end
            ST_FPREP:
            begin
                rem_next   = nmag[DIV_W-1:0] + DIV_W'(den >> 1);
                dv_next    = {den, (DIV_QW - 1)'(0)};
                qneg_next  = num_reg[41];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                rem_next = div_ge ? (rem_reg - dv_reg) : rem_reg;
                quo_next = {quo_reg[DIV_QW-2:0], div_ge};
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_QW - 1))
                begin
                    state_next = ST_FSAT;
                end
            end
            ST_FSAT:
            begin
                y_next     = sat_s24(27'(yq));
                fm_next    = sat_s24(27'(yq));
                state_next = ST_GMUL;
            end
            ST_GMUL:
            begin
                gprod_next = y_reg * gain_c;
                state_next = ST_FBABS;
            end
            ST_FBABS:
            begin
                pneg_next  = gprod_reg[39];
                pmag_next  = gprod_reg[39] ? 40'(-gprod_reg) : 40'(gprod_reg);
                flush_next = gprod_reg[39] ? (-gprod_reg <= 40'sd137438)
                                           : (gprod_reg <= 40'sd137438);
                state_next = ST_FBRND;
            end
            ST_FBRND:
            begin
                if (flush_reg)
                begin
                    feed_next = '0;
                end
                else if (pneg_reg)
                begin
                    feed_next = -$signed(rnd);
                end
                else
                begin
                    feed_next = $signed(rnd);
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (wp_reg == LAST)
                begin
                    wp_next     = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            fm_reg        <= '0;
            mute_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            interp_reg    <= 1'b1;
            filt_reg      <= 1'b0;
            coef_reg      <= COEF_W'(8192);
            prot_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            fm_reg        <= fm_next;
            mute_reg      <= mute_next;
            hold_reg      <= hold_next;
            interp_reg    <= interp_next;
            filt_reg      <= filt_next;
            coef_reg      <= coef_next;
            prot_reg      <= prot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        smp_reg        <= smp_next;
        dly_reg        <= dly_next;
        gain_reg       <= gain_next;
        ip_reg         <= ip_next;
        fr_reg         <= fr_next;
        p1_reg         <= p1_next;
        p0_reg         <= p0_next;
        x1_reg         <= x1_next;
        x0_reg         <= x0_next;
        iprod_reg      <= iprod_next;
        tap_reg        <= tap_next;
        fprod_reg      <= fprod_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        dv_reg         <= dv_next;
        quo_reg        <= quo_next;
        qneg_reg       <= qneg_next;
        cnt_reg        <= cnt_next;
        y_reg          <= y_next;
        gprod_reg      <= gprod_next;
        pmag_reg       <= pmag_next;
        pneg_reg       <= pneg_next;
        flush_reg      <= flush_next;
        feed_reg       <= feed_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            delay_store[wp_reg] <= wr_data;
        end
        rd_data_reg <= delay_store[rd_addr];
    end

endmodule

// ===== hdl/ffdl_checker.sv =====
// ----------------------------------------------------------------------------
// ffdl_checker
// Port-level checks of the fractional feedback delay line, bound to the top.
// ----------------------------------------------------------------------------
module ffdl_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [ffdl_pkg::SAMPLE_W-1:0] out_sample
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_sample))
        else $error("stalled result beat changed or dropped");

    // one item in flight: stall right after an input beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // a new result frees the input side
    a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result registered while input still stalled");

    // no result in the cycle after an input beat
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind fractional_feedback_delay_line ffdl_checker u_ffdl_checker (.*);
